@@ rtl/lrut_pkg.sv @@
// Package for the LRU eviction table: sizes, operation and status codes, entry record.
// Depends on nothing; every other file but lrut_channels imports it.
package lrut_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int MAX_RESULTS = 64;
   localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);
   // Sum of all sizes never overflows this width.
   localparam int TOTAL_W     = 40 + ADDR_W;
   localparam int FREED_W     = 49 + ADDR_W;

   typedef enum logic [2:0] {
      OP_CLEAR   = 3'd0,
      OP_ADD     = 3'd1,
      OP_REMOVE  = 3'd2,
      OP_NOTE    = 3'd3,
      OP_LOOKUP  = 3'd4,
      OP_PROTECT = 3'd5,
      OP_EVICT   = 3'd6,
      OP_NONE    = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      STS_DONE   = 2'd0,
      STS_MISS   = 2'd1,
      STS_BADKEY = 2'd2,
      STS_FULL   = 2'd3
   } status_type;

   typedef struct packed {
      logic [63:0] key;
      logic [39:0] nbytes;
      logic [39:0] played;
      logic [31:0] plays;
   } entry_type;

   typedef logic [ADDR_W-1:0] addr_type;

endpackage

@@ rtl/lrut_channels.sv @@
// Channel interfaces of the LRU eviction table: request, response and register write.
// Depends on nothing.
interface lrut_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [63:0] key;
   logic [39:0] item_bytes;
   logic [39:0] time_stamp;
   logic [31:0] play_count;
   logic [47:0] bytes_to_free;
   modport source(output valid, operation, key, item_bytes, time_stamp, play_count,
                  bytes_to_free, input ready);
   modport sink(input valid, operation, key, item_bytes, time_stamp, play_count,
                bytes_to_free, output ready);
endinterface

interface lrut_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] entry_key;
   logic [39:0] entry_bytes;
   logic [39:0] last_played;
   logic [31:0] times_played;
   logic [47:0] total_bytes;
   logic [47:0] headroom_bytes;
   logic        last;
   modport source(output valid, status, entry_key, entry_bytes, last_played, times_played,
                  total_bytes, headroom_bytes, last, input ready);
   modport sink(input valid, status, entry_key, entry_bytes, last_played, times_played,
                total_bytes, headroom_bytes, last, output ready);
endinterface

interface lrut_csr_if;
   logic        valid;
   logic        ready;
   logic [47:0] data;
   modport source(output valid, data, input ready);
   modport sink(input valid, data, output ready);
endinterface

@@ rtl/lrut_store.sv @@
// Entry memory of the LRU eviction table: one write port, one read port, registered read.
// Depends on lrut_pkg.
module lrut_store
   import lrut_pkg::*;
(
   input  logic      clock,
   input  addr_type  rd_addr,
   output entry_type rd_data,
   input  logic      wr_en,
   input  addr_type  wr_addr,
   input  entry_type wr_data
);

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lru_eviction_table_unit.sv @@
// Top level of the LRU eviction table: sequencer, flag bits, totals and response register.
// Depends on lrut_pkg, lrut_channels and lrut_store.
//
//   channel | direction | transaction
//   req     | in        | one operation with key, size, time, count and target
//   rsp     | out       | one result; an evict gives up to 64, the final one marked last
//   csr     | in        | capacity write (max_bytes), always ready
//
// Clear, OP_NONE and an evict with a zero target go straight to the decision state.
// Every other operation scans the entry memory once through the single read port.
// An evict repeats that scan once per key it emits.
// Reset is synchronous; it empties the table and the capacity register.
// A stalled response holds the sequencer in its decision state; nothing is lost.
module lru_eviction_table_unit
   import lrut_pkg::*;
(
   input logic    clock,
   input logic    reset,
   lrut_req_if.sink   req,
   lrut_rsp_if.source rsp,
   lrut_csr_if.sink   csr
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_DECIDE = 3'b100
   } state_type;

   state_type state_ff;
   logic [47:0] max_bytes_ff;

   op_type      op_ff;
   logic [63:0] key_ff;
   logic [39:0] ibytes_ff;
   logic [39:0] stamp_ff;
   logic [31:0] count_ff;
   logic [47:0] target_ff;

   logic [TABLE_DEPTH-1:0] valid_ff, prot_ff, chosen_ff;
   logic [TOTAL_W-1:0]     total_ff;

   logic [ADDR_W:0] cnt_ff;
   logic            issue_ff;
   addr_type        idx_ff;
   logic            hit_ff;
   addr_type        hit_idx_ff;
   entry_type       hit_data_ff;
   logic            free_found_ff;
   addr_type        free_idx_ff;
   logic [ADDR_W:0] elig_cnt_ff;
   logic [FREED_W-1:0] freed_ff;
   logic [RCNT_W-1:0]  rcnt_ff;

   logic        rsp_valid_ff;
   status_type  rsp_status_ff;
   entry_type   rsp_entry_ff;
   logic [47:0] rsp_total_ff;
   logic [47:0] rsp_head_ff;
   logic        rsp_last_ff;

   entry_type rd_data;
   logic      wr_en;
   addr_type  wr_addr;

   // Register write port.
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= '0;
      end else if (csr.valid) begin
         max_bytes_ff <= csr.data;
      end
   end

   // Handshakes.
   logic req_fire, out_free;
   assign req.ready = (state_ff == S_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   // Scan evaluation of the entry returned by the memory this cycle.
   logic        evict_mode, cand_elig, better, take, scan_end, issuing;
   logic [40:0] age_rd, age_hit;
   assign evict_mode = (op_ff == OP_EVICT);
   assign age_rd  = (rd_data.played == '0) ? {1'b1, 40'b0} : {1'b0, rd_data.played};
   assign age_hit = (hit_data_ff.played == '0) ? {1'b1, 40'b0} : {1'b0, hit_data_ff.played};
   assign cand_elig = valid_ff[idx_ff] &&
                      (evict_mode ? (!prot_ff[idx_ff] && !chosen_ff[idx_ff])
                                  : (rd_data.key == key_ff));
   assign better = !hit_ff || (evict_mode && ((age_rd < age_hit) ||
                   ((age_rd == age_hit) && (rd_data.key < hit_data_ff.key))));
   assign take     = issue_ff && cand_elig && better;
   assign scan_end = issue_ff && (idx_ff == ADDR_W'(TABLE_DEPTH - 1));
   assign issuing  = (state_ff == S_SCAN) && (cnt_ff < (ADDR_W + 1)'(TABLE_DEPTH));

   // Decision for the operation once the scan is over.
   status_type  d_status;
   entry_type   d_entry;
   logic        d_last, d_add, d_note, d_remove, d_protect, d_clear, d_choose, d_more;
   logic [TOTAL_W-1:0] d_total;
   logic [FREED_W-1:0] d_freed;
   always_comb begin
      d_status  = STS_MISS;
      d_entry   = '{key: key_ff, nbytes: '0, played: '0, plays: '0};
      d_last    = 1'b1;
      d_add     = 1'b0;
      d_note    = 1'b0;
      d_remove  = 1'b0;
      d_protect = 1'b0;
      d_clear   = 1'b0;
      d_choose  = 1'b0;
      d_more    = 1'b0;
      d_total   = total_ff;
      d_freed   = freed_ff + FREED_W'(hit_data_ff.nbytes);
      unique case (op_ff)
         OP_CLEAR: begin
            d_status = STS_DONE;
            d_clear  = 1'b1;
            d_total  = '0;
         end
         OP_ADD: begin
            if (key_ff == '0 || hit_ff) begin
               d_status = STS_BADKEY;
            end else if (!free_found_ff) begin
               d_status = STS_FULL;
            end else begin
               d_status = STS_DONE;
               d_entry  = '{key: key_ff, nbytes: ibytes_ff, played: stamp_ff,
                            plays: count_ff};
               d_add    = 1'b1;
               d_total  = total_ff + TOTAL_W'(ibytes_ff);
            end
         end
         OP_REMOVE: begin
            if (hit_ff) begin
               d_status = STS_DONE;
               d_entry  = hit_data_ff;
               d_remove = 1'b1;
               d_total  = total_ff - TOTAL_W'(hit_data_ff.nbytes);
            end
         end
         OP_NOTE: begin
            if (hit_ff) begin
               d_status       = STS_DONE;
               d_entry        = hit_data_ff;
               d_entry.played = stamp_ff;
               if (hit_data_ff.plays != '1) begin
                  d_entry.plays = hit_data_ff.plays + 32'd1;
               end
               d_note = 1'b1;
            end
         end
         OP_LOOKUP: begin
            if (hit_ff) begin
               d_status = STS_DONE;
               d_entry  = hit_data_ff;
            end
         end
         OP_PROTECT: begin
            if (hit_ff) begin
               d_status  = STS_DONE;
               d_entry   = hit_data_ff;
               d_protect = 1'b1;
            end
         end
         OP_EVICT: begin
            if (hit_ff) begin
               d_status = STS_DONE;
               d_entry  = hit_data_ff;
               d_choose = 1'b1;
               d_last   = (d_freed >= FREED_W'(target_ff)) ||
                          (rcnt_ff == RCNT_W'(MAX_RESULTS - 1)) ||
                          (elig_cnt_ff <= (ADDR_W + 1)'(1));
               d_more   = !d_last;
            end else begin
               d_entry.key = '0;
            end
         end
         OP_NONE: begin
            d_status = STS_MISS;
         end
         default: begin
            d_status = STS_MISS;
         end
      endcase
   end

   // Total of the decision, saturated to 48 bits.
   logic [TOTAL_W+47:0] d_total_wide;
   logic [47:0]         d_total_sat;
   assign d_total_wide = {48'b0, d_total};
   assign d_total_sat  = (d_total_wide[TOTAL_W+47:48] != '0) ? '1 : d_total_wide[47:0];

   logic decide_fire;
   assign decide_fire = (state_ff == S_DECIDE) && out_free;

   // Memory ports.
   assign wr_en   = decide_fire && (d_add || d_note);
   assign wr_addr = d_add ? free_idx_ff : hit_idx_ff;

   lrut_store u_store (
      .clock   (clock),
      .rd_addr (cnt_ff[ADDR_W-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (d_entry)
   );

   // Sequencer and table flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         prot_ff       <= '0;
         chosen_ff     <= '0;
         total_ff      <= '0;
         cnt_ff        <= '0;
         issue_ff      <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         elig_cnt_ff   <= '0;
         freed_ff      <= '0;
         rcnt_ff       <= '0;
         op_ff         <= OP_NONE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  op_ff         <= op_type'(req.operation);
                  hit_ff        <= 1'b0;
                  free_found_ff <= 1'b0;
                  elig_cnt_ff   <= '0;
                  cnt_ff        <= '0;
                  issue_ff      <= 1'b0;
                  if (op_type'(req.operation) == OP_EVICT) begin
                     chosen_ff <= '0;
                     freed_ff  <= '0;
                     rcnt_ff   <= '0;
                  end
                  if (op_type'(req.operation) == OP_CLEAR ||
                      op_type'(req.operation) == OP_NONE ||
                      (op_type'(req.operation) == OP_EVICT && req.bytes_to_free == '0)) begin
                     state_ff <= S_DECIDE;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (issuing) begin
                  cnt_ff <= cnt_ff + (ADDR_W + 1)'(1);
               end
               issue_ff <= issuing;
               if (take) begin
                  hit_ff <= 1'b1;
               end
               if (issue_ff && !valid_ff[idx_ff] && !free_found_ff) begin
                  free_found_ff <= 1'b1;
               end
               if (issue_ff && cand_elig && evict_mode) begin
                  elig_cnt_ff <= elig_cnt_ff + (ADDR_W + 1)'(1);
               end
               if (scan_end) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               if (out_free) begin
                  total_ff <= d_total;
                  if (d_clear) begin
                     valid_ff <= '0;
                     prot_ff  <= '0;
                  end
                  if (d_add) begin
                     valid_ff[free_idx_ff] <= 1'b1;
                     prot_ff[free_idx_ff]  <= 1'b0;
                  end
                  if (d_remove) begin
                     valid_ff[hit_idx_ff] <= 1'b0;
                     prot_ff[hit_idx_ff]  <= 1'b0;
                  end
                  if (d_protect) begin
                     prot_ff[hit_idx_ff] <= 1'b1;
                  end
                  if (d_choose) begin
                     chosen_ff[hit_idx_ff] <= 1'b1;
                     freed_ff              <= d_freed;
                     rcnt_ff               <= rcnt_ff + RCNT_W'(1);
                  end
                  if (op_ff == OP_EVICT && d_last) begin
                     prot_ff <= '0;
                  end
                  if (d_more) begin
                     hit_ff      <= 1'b0;
                     elig_cnt_ff <= '0;
                     cnt_ff      <= '0;
                     issue_ff    <= 1'b0;
                     state_ff    <= S_SCAN;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Scan payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         key_ff    <= req.key;
         ibytes_ff <= req.item_bytes;
         stamp_ff  <= req.time_stamp;
         count_ff  <= req.play_count;
         target_ff <= req.bytes_to_free;
      end
      idx_ff <= cnt_ff[ADDR_W-1:0];
      if (take) begin
         hit_idx_ff  <= idx_ff;
         hit_data_ff <= rd_data;
      end
      if (issue_ff && !valid_ff[idx_ff] && !free_found_ff) begin
         free_idx_ff <= idx_ff;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (decide_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (decide_fire) begin
         rsp_status_ff <= d_status;
         rsp_entry_ff  <= d_entry;
         rsp_total_ff  <= d_total_sat;
         rsp_head_ff   <= (max_bytes_ff > d_total_sat) ? (max_bytes_ff - d_total_sat) : '0;
         rsp_last_ff   <= d_last;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.entry_key      = rsp_entry_ff.key;
   assign rsp.entry_bytes    = rsp_entry_ff.nbytes;
   assign rsp.last_played    = rsp_entry_ff.played;
   assign rsp.times_played   = rsp_entry_ff.plays;
   assign rsp.total_bytes    = rsp_total_ff;
   assign rsp.headroom_bytes = rsp_head_ff;
   assign rsp.last           = rsp_last_ff;

endmodule

@@ tb/lrut_scoreboard.sv @@
// Scoreboard for the LRU eviction table: a behavioral copy of the table and a queue of
// expected results. Depends on lrut_pkg.
import lrut_pkg::*;

typedef struct packed {
   logic [1:0]  status;
   logic [63:0] entry_key;
   logic [39:0] entry_bytes;
   logic [39:0] last_played;
   logic [31:0] times_played;
   logic [47:0] total_bytes;
   logic [47:0] headroom_bytes;
   logic        last;
} cache_result_type;

class lrut_scoreboard;
   bit          used[TABLE_DEPTH];
   entry_type   slots[TABLE_DEPTH];
   bit          guarded[TABLE_DEPTH];
   logic [47:0] capacity;
   logic [47:0] held;
   cache_result_type pending[$];
   int          errors;
   int          checked;
   int          evict_keys;

   function void wipe();
      foreach (used[i]) begin
         used[i] = 0;
         guarded[i] = 0;
         slots[i] = '0;
      end
      capacity = 0;
      held = 0;
   endfunction

   function void set_capacity(logic [47:0] value);
      capacity = value;
   endfunction

   function void recount();
      logic [63:0] sum;
      sum = 0;
      foreach (used[i])
         if (used[i])
            sum += slots[i].nbytes;
      held = (sum > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : sum[47:0];
   endfunction

   function int locate(logic [63:0] key);
      foreach (used[i])
         if (used[i] && slots[i].key == key)
            return i;
      return -1;
   endfunction

   // Queue one expected result; a negative slot echoes the key with zero entry fields.
   function void expect_result(status_type sts, int slot, logic [63:0] key, bit fin);
      cache_result_type r;
      r = '0;
      r.status = sts;
      if (slot >= 0) begin
         r.entry_key = slots[slot].key;
         r.entry_bytes = slots[slot].nbytes;
         r.last_played = slots[slot].played;
         r.times_played = slots[slot].plays;
      end else begin
         r.entry_key = key;
      end
      r.total_bytes = held;
      r.headroom_bytes = (capacity > held) ? capacity - held : '0;
      r.last = fin;
      pending.insert(pending.size(), r);
   endfunction

   function logic [40:0] age(int i);
      return (slots[i].played == 0) ? 41'h100_0000_0000 : {1'b0, slots[i].played};
   endfunction

   // Note one accepted request and predict what it yields.
   function void note_request(op_type op, logic [63:0] key, logic [39:0] nbytes,
                              logic [39:0] stamp, logic [31:0] plays, logic [47:0] target);
      int s;
      int i;
      int best;
      int n;
      bit chosen[TABLE_DEPTH];
      logic [63:0] freed;
      s = (op >= OP_ADD && op <= OP_PROTECT) ? locate(key) : -1;
      case (op)
         OP_CLEAR: begin
            foreach (used[k]) begin
               used[k] = 0;
               guarded[k] = 0;
            end
            held = 0;
            expect_result(STS_DONE, -1, key, 1);
         end
         OP_ADD: begin
            if (key == 0 || s >= 0) begin
               expect_result(STS_BADKEY, -1, key, 1);
            end else begin
               for (i = 0; i < TABLE_DEPTH; i++)
                  if (!used[i])
                     break;
               if (i >= TABLE_DEPTH) begin
                  expect_result(STS_FULL, -1, key, 1);
               end else begin
                  used[i] = 1;
                  slots[i] = '{key: key, nbytes: nbytes, played: stamp, plays: plays};
                  guarded[i] = 0;
                  recount();
                  expect_result(STS_DONE, i, key, 1);
               end
            end
         end
         OP_REMOVE: begin
            if (s < 0) begin
               expect_result(STS_MISS, -1, key, 1);
            end else begin
               used[s] = 0;
               guarded[s] = 0;
               recount();
               expect_result(STS_DONE, s, key, 1);
            end
         end
         OP_NOTE: begin
            if (s >= 0) begin
               slots[s].played = stamp;
               if (slots[s].plays != 32'hFFFF_FFFF)
                  slots[s].plays++;
            end
            expect_result(s >= 0 ? STS_DONE : STS_MISS, s, key, 1);
         end
         OP_LOOKUP: expect_result(s >= 0 ? STS_DONE : STS_MISS, s, key, 1);
         OP_PROTECT: begin
            if (s >= 0)
               guarded[s] = 1;
            expect_result(s >= 0 ? STS_DONE : STS_MISS, s, key, 1);
         end
         OP_EVICT: begin
            n = 0;
            freed = 0;
            foreach (chosen[k])
               chosen[k] = 0;
            // Oldest first, never-played last, ties by the smaller key.
            if (target != 0) begin
               while (n < MAX_RESULTS) begin
                  best = -1;
                  for (i = 0; i < TABLE_DEPTH; i++) begin
                     if (!used[i] || guarded[i] || chosen[i])
                        continue;
                     if (best < 0 || age(i) < age(best) ||
                         (age(i) == age(best) && slots[i].key < slots[best].key))
                        best = i;
                  end
                  if (best < 0)
                     break;
                  chosen[best] = 1;
                  freed += slots[best].nbytes;
                  expect_result(STS_DONE, best, 0, 0);
                  n++;
                  if (freed >= target)
                     break;
               end
            end
            foreach (guarded[k])
               guarded[k] = 0;
            evict_keys += n;
            if (n == 0)
               expect_result(STS_MISS, -1, 0, 1);
            else
               pending[$].last = 1;
         end
         default: expect_result(STS_MISS, -1, key, 1);
      endcase
   endfunction

   // Compare one accepted result with the oldest expectation.
   function void check_result(cache_result_type got);
      cache_result_type exp;
      checked++;
      if (pending.size() == 0) begin
         $error("unexpected result: key %h status %0d", got.entry_key, got.status);
         errors++;
         return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
         $error("status: expected %0d, got %0d", exp.status, got.status); errors++;
      end
      if (got.entry_key !== exp.entry_key) begin
         $error("entry_key: expected %h, got %h", exp.entry_key, got.entry_key); errors++;
      end
      if (got.entry_bytes !== exp.entry_bytes) begin
         $error("entry_bytes: expected %h, got %h", exp.entry_bytes, got.entry_bytes);
         errors++;
      end
      if (got.last_played !== exp.last_played) begin
         $error("last_played: expected %h, got %h", exp.last_played, got.last_played);
         errors++;
      end
      if (got.times_played !== exp.times_played) begin
         $error("times_played: expected %h, got %h", exp.times_played, got.times_played);
         errors++;
      end
      if (got.total_bytes !== exp.total_bytes) begin
         $error("total_bytes: expected %h, got %h", exp.total_bytes, got.total_bytes);
         errors++;
      end
      if (got.headroom_bytes !== exp.headroom_bytes) begin
         $error("headroom_bytes: expected %h, got %h", exp.headroom_bytes,
                got.headroom_bytes);
         errors++;
      end
      if (got.last !== exp.last) begin
         $error("last: expected %0d, got %0d", exp.last, got.last); errors++;
      end
   endfunction
endclass

@@ tb/tb.sv @@
// Testbench top for lru_eviction_table_unit: directed and random cache operations with
// random idling on both channels. Depends on lrut_pkg, lrut_channels and lrut_scoreboard.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lrut_pkg::*;

   logic clock = 0;
   logic reset = 1;
   lrut_req_if req();
   lrut_rsp_if rsp();
   lrut_csr_if csr();
   lrut_scoreboard board = new();
   logic [63:0] key_pool[16];
   int hold_off = 0;

   lru_eviction_table_unit u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   always #5 clock = ~clock;

   // Sample accepted results at the rising edge; ready changes at the falling edge.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         board.check_result('{rsp.status, rsp.entry_key, rsp.entry_bytes, rsp.last_played,
                              rsp.times_played, rsp.total_bytes, rsp.headroom_bytes,
                              rsp.last});
   end

   // Receiver: random stall before each result, plus one long hold-off on request.
   initial begin
      int gap;
      rsp.ready = 0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp.ready <= 0;
            repeat (hold_off) @(negedge clock);
            hold_off = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp.ready <= 0;
            repeat (gap - 1) @(negedge clock);
         end else begin
            rsp.ready <= 1;
            do @(posedge clock); while (!(rsp.valid && rsp.ready));
         end
      end
   end

   task automatic write_capacity(logic [47:0] value);
      csr.valid <= 1;
      csr.data <= value;
      do @(posedge clock); while (!csr.ready);
      board.set_capacity(value);
      @(negedge clock);
      csr.valid <= 0;
   endtask

   // Offer one request after a random gap and wait for its acceptance. Valid stays high
   // after acceptance until the next request, an idle gap or drain() replaces it.
   task automatic send(op_type op, logic [63:0] key, logic [39:0] nbytes = 0,
                       logic [39:0] stamp = 0, logic [31:0] plays = 0,
                       logic [47:0] target = 0, bit no_gap = 0);
      int gap;
      gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req.valid <= 1;
      req.operation <= op;
      req.key <= key;
      req.item_bytes <= nbytes;
      req.time_stamp <= stamp;
      req.play_count <= plays;
      req.bytes_to_free <= target;
      do @(posedge clock); while (!req.ready);
      board.note_request(op, key, nbytes, stamp, plays, target);
      @(negedge clock);
   endtask

   task automatic drain();
      int guard;
      req.valid <= 0;
      guard = 0;
      while (board.pending.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (TABLE_DEPTH + 10) @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [39:0] rand40();
      return {$urandom_range(0, 255), $urandom()};
   endfunction

   // Random operation mix weighted toward a pool of 16 reused keys.
   task automatic random_item(bit no_gap);
      logic [63:0] key;
      int pick;
      op_type op;
      pick = $urandom_range(0, 99);
      key = ($urandom_range(0, 9) == 0) ? rand64() : key_pool[$urandom_range(0, 15)];
      if (pick < 30) op = OP_ADD;
      else if (pick < 42) op = OP_NOTE;
      else if (pick < 52) op = OP_LOOKUP;
      else if (pick < 62) op = OP_PROTECT;
      else if (pick < 72) op = OP_REMOVE;
      else if (pick < 92) op = OP_EVICT;
      else if (pick < 96) op = OP_NONE;
      else op = OP_CLEAR;
      send(op, key, ($urandom_range(0, 7) == 0) ? rand40() : 40'($urandom_range(0, 5000)),
           ($urandom_range(0, 4) == 0) ? 40'd0 : {32'd0, 8'($urandom_range(0, 30))} |
           (($urandom_range(0, 5) == 0) ? rand40() : 40'd0),
           ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFE + $urandom_range(0, 1) : $urandom(),
           ($urandom_range(0, 9) == 0) ? {$urandom(), 16'($urandom())}
                                       : 48'($urandom_range(0, 12000)),
           no_gap);
   endtask

   initial begin
      int i;
      req.valid = 0;
      req.operation = OP_NONE;
      req.key = 0;
      req.item_bytes = 0;
      req.time_stamp = 0;
      req.play_count = 0;
      req.bytes_to_free = 0;
      csr.valid = 0;
      csr.data = 0;
      board.wipe();
      foreach (key_pool[k])
         key_pool[k] = (k == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : (k == 1) ? 64'd1 : rand64() | 1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: every operation, field extremes and the special cases.
      write_capacity(48'hFFFF_FFFF_FFFF);
      send(OP_ADD, 64'd0, 40'd5);                                  // zero key refused
      send(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF,
           32'hFFFF_FFFF);
      send(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 40'd1);                // duplicate
      send(OP_ADD, 64'd1, 40'd100, 40'd0, 32'd0);
      send(OP_ADD, 64'd2, 40'd200, 40'd10, 32'd3);
      send(OP_ADD, 64'd3, 40'd300, 40'd10, 32'd4);
      send(OP_NOTE, 64'hFFFF_FFFF_FFFF_FFFF, 40'd5);               // count saturates
      send(OP_NOTE, 64'd2, 40'd0);                                 // back to never-played
      send(OP_NOTE, 64'd99, 40'd7);
      send(OP_LOOKUP, 64'd3);
      send(OP_LOOKUP, 64'd98);
      send(OP_PROTECT, 64'd3);
      send(OP_PROTECT, 64'd97);
      send(OP_EVICT, 0, 0, 0, 0, 48'd0);                           // zero target
      send(OP_EVICT, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF);
      send(OP_REMOVE, 64'd3);
      send(OP_REMOVE, 64'd3);
      send(OP_NONE, 64'd55);
      send(OP_CLEAR, 64'hA5A5);
      send(OP_EVICT, 0, 0, 0, 0, 48'd1);                           // nothing to choose
      drain();

      // Fill the table past full, then evict everything: the result cap.
      write_capacity(48'd0);
      for (i = 0; i <= TABLE_DEPTH; i++)
         send(OP_ADD, 64'h1000 + i, 40'h80_0000_0000, 40'($urandom_range(0, 3)), 0, 0,
              i > 4);
      send(OP_EVICT, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF);
      drain();

      // Random phases with different capacities; one long receiver hold-off.
      write_capacity(48'd20000);
      send(OP_CLEAR, 0);
      hold_off = 300;
      for (i = 0; i < 12; i++)
         random_item(1);
      drain();
      write_capacity({$urandom(), 16'($urandom())});
      for (i = 0; i < 11; i++)
         random_item(0);
      drain();

      $display("Ran %0d results, %0d keys chosen by evictions, across several capacities.",
               board.checked, board.evict_keys);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #20ms;
      $display("Timeout after %0d results", board.checked);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/lrut_pkg.sv
rtl/lrut_channels.sv
rtl/lrut_store.sv
rtl/lru_eviction_table_unit.sv
tb/lrut_scoreboard.sv
tb/tb.sv
